FILE: hdl/sparse_set_component_pool_unit_macros.svh
// Assertion helpers for the component pool, clocked on clk_i, idle while rst_ni is low.
`ifndef SPARSE_SET_COMPONENT_POOL_UNIT_MACROS_SVH
`define SPARSE_SET_COMPONENT_POOL_UNIT_MACROS_SVH

// Property that must hold at every edge.
`define SSCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define SSCP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sscp_pkg.sv
`timescale 1ns / 1ps

package sscp_pkg;

  localparam int unsigned DEF_MAX_ENTITIES   = 1024;
  localparam int unsigned DEF_CAPACITY       = 1024;
  localparam int unsigned DEF_COMPONENT_BITS = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BEYOND = 2'd3
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [9:0]  entity_id;
    logic [31:0] component_value;
    logic [9:0]  slot_index;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] data_out;
    logic [9:0]  entity_out;
    logic [10:0] live_count;
  } out_t;

endpackage

FILE: hdl/sscp_ram.sv
`timescale 1ns / 1ps

// Single write port, single registered read port.
module sscp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sparse_set_component_pool_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_ready_o  in_data_i  (in_t)
// out      output     out_valid_o / out_ready_i out_data_o (out_t)
//
// Insert, remove without a move, lookup miss and slot read pass through S_MAP and S_RESULT;
// lookup hit and remove with a move also pass S_DENSE or S_MOVE, as the map read must return
// before the dependent dense memory read can be issued. The next word is taken in S_RESULT.
// After reset a clearing pass writes every map entry with in_ready_o low.
// A finished word waits in a holding register while the output register is full.
`include "sparse_set_component_pool_unit_macros.svh"

module sparse_set_component_pool_unit import sscp_pkg::*; #(
  parameter int unsigned MAX_ENTITIES   = DEF_MAX_ENTITIES,
  parameter int unsigned CAPACITY       = DEF_CAPACITY,
  parameter int unsigned COMPONENT_BITS = DEF_COMPONENT_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned EW = $clog2(MAX_ENTITIES);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = SW + 1;               // valid + slot
  localparam int unsigned DW = COMPONENT_BITS + EW;  // component + owner

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MAP    = 5'b00010,
    S_MOVE   = 5'b00100,
    S_DENSE  = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  in_t    req_q, req_d;
  out_t   res_q, res_d;
  out_t   out_q;
  logic   out_valid_q;
  logic [SW-1:0] slot_q, slot_d;
  logic [CW-1:0] count_q, count_d;
  logic [EW-1:0] clr_addr_q;
  logic          clr_busy_q;

  logic          map_we, map_re;
  logic [EW-1:0] map_waddr, map_raddr;
  logic [MW-1:0] map_wdata, map_rdata;
  logic          dense_we, dense_re;
  logic [SW-1:0] dense_waddr, dense_raddr;
  logic [DW-1:0] dense_wdata, dense_rdata;

  logic                      map_valid_rd;
  logic [SW-1:0]             map_slot_rd;
  logic [COMPONENT_BITS-1:0] comp_rd;
  logic [EW-1:0]             owner_rd;
  logic                      ent_ok, map_hit, out_free, in_acc;
  logic [CW-1:0]             last;

  sscp_ram #(.WIDTH(MW), .DEPTH(MAX_ENTITIES)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  sscp_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_dense (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (dense_wdata),
    .re_i    (dense_re),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  assign map_valid_rd = map_rdata[SW];
  assign map_slot_rd  = map_rdata[SW-1:0];
  assign comp_rd      = dense_rdata[DW-1:EW];
  assign owner_rd     = dense_rdata[EW-1:0];

  assign ent_ok   = 32'(req_q.entity_id) < 32'(MAX_ENTITIES);
  // stale map slots at or past the count mean absent
  assign map_hit  = map_valid_rd && ent_ok && (32'(map_slot_rd) < 32'(count_q));
  assign last     = count_q - CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = !clr_busy_q &&
                      ((state_q == S_IDLE) || ((state_q == S_RESULT) && out_free));
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    slot_d      = slot_q;
    count_d     = count_q;
    map_we      = 1'b0;
    map_waddr   = EW'(req_q.entity_id);
    map_wdata   = '0;
    map_re      = 1'b0;
    map_raddr   = EW'(in_data_i.entity_id);
    dense_we    = 1'b0;
    dense_waddr = map_slot_rd;
    dense_wdata = '0;
    dense_re    = 1'b0;
    dense_raddr = SW'(in_data_i.slot_index);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d    = in_data_i;
          map_re   = 1'b1;
          dense_re = 1'b1;
          state_d  = S_MAP;
        end
      end
      S_MAP: begin
        res_d.status     = STAT_DONE;
        res_d.data_out   = '0;
        res_d.entity_out = '0;
        state_d          = S_RESULT;
        case (req_q.opcode)
          OP_INSERT: begin
            if (map_hit) begin
              dense_we    = 1'b1;
              dense_wdata = {COMPONENT_BITS'(req_q.component_value), EW'(req_q.entity_id)};
            end else if (!ent_ok) begin
              res_d.status = STAT_ABSENT;
            end else if (32'(count_q) >= 32'(CAPACITY)) begin
              res_d.status = STAT_FULL;
            end else begin
              dense_we    = 1'b1;
              dense_waddr = SW'(count_q);
              dense_wdata = {COMPONENT_BITS'(req_q.component_value), EW'(req_q.entity_id)};
              map_we      = 1'b1;
              map_wdata   = {1'b1, SW'(count_q)};
              count_d     = count_q + CW'(1);
            end
          end
          OP_REMOVE: begin
            if (!map_hit) begin
              res_d.status = STAT_ABSENT;
            end else begin
              map_we    = 1'b1;
              map_wdata = {1'b0, map_slot_rd};
              count_d   = last;
              if (32'(map_slot_rd) != 32'(last)) begin
                // swap-and-pop: fetch the last entry to fill the hole
                dense_re    = 1'b1;
                dense_raddr = SW'(last);
                slot_d      = map_slot_rd;
                state_d     = S_MOVE;
              end
            end
          end
          OP_LOOKUP: begin
            if (!map_hit) begin
              res_d.status = STAT_ABSENT;
            end else begin
              dense_re    = 1'b1;
              dense_raddr = map_slot_rd;
              state_d     = S_DENSE;
            end
          end
          default: begin
            // dense slot read was issued on accept
            if (32'(req_q.slot_index) < 32'(count_q)) begin
              res_d.data_out   = 32'(comp_rd);
              res_d.entity_out = 10'(owner_rd);
            end else begin
              res_d.status = STAT_BEYOND;
            end
          end
        endcase
        res_d.live_count = 11'(count_d);
      end
      S_MOVE: begin
        dense_we         = 1'b1;
        dense_waddr      = slot_q;
        dense_wdata      = dense_rdata;
        map_we           = 1'b1;
        map_waddr        = owner_rd;
        map_wdata        = {1'b1, slot_q};
        res_d.live_count = 11'(count_q);
        state_d          = S_RESULT;
      end
      S_DENSE: begin
        res_d.data_out   = 32'(comp_rd);
        res_d.live_count = 11'(count_q);
        state_d          = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (in_acc) begin
            req_d    = in_data_i;
            map_re   = 1'b1;
            dense_re = 1'b1;
            state_d  = S_MAP;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clr_busy_q) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_q;
      map_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + EW'(1);
        if (clr_addr_q == EW'(MAX_ENTITIES - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    slot_q <= slot_d;
    if ((state_q == S_RESULT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSCP_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `SSCP_ASSERT(a_no_accept_clearing, !(clr_busy_q && in_ready_o), "word accepted during map clear")
  `SSCP_ASSERT(a_count_bound, 32'(count_q) <= 32'(CAPACITY), "live count above capacity")
  `SSCP_ASSERT_NEXT(a_accept_to_map, in_acc, state_q == S_MAP, "accepted word not in map stage")
  `SSCP_ASSERT_NEXT(a_count_only_in_map, state_q != S_MAP, $stable(count_q), "count moved outside map stage")

endmodule

FILE: tb/sparse_set_component_pool_unit_test.sv
`timescale 1ns / 1ps

module sparse_set_component_pool_unit_test;
  import sscp_pkg::*;

  localparam int unsigned POOL_SLOTS  = DEF_CAPACITY;
  localparam int unsigned ENTITIES    = DEF_MAX_ENTITIES;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned RUN_LIMIT   = 200000;

  localparam bit KNOWN   = 1'b1;
  localparam bit DERIVED = 1'b0;

  typedef struct packed {
    in_t  word;
    bit   known;
    out_t res;
  } probe_row_t;

  localparam int unsigned N_PROBES = 25;

  // Directed opening from an empty pool. Removes are arranged so that moves into slot 0
  // and a removal of the last slot occur.
  localparam probe_row_t PROBES [N_PROBES] = '{
    '{'{OP_LOOKUP, 10'h000, 32'h0000_0000, 10'h3ff}, KNOWN,   '{STAT_ABSENT, 32'h0, 10'h0, 11'd0}},
    '{'{OP_READ,   10'h3ff, 32'hffff_ffff, 10'h000}, KNOWN,   '{STAT_BEYOND, 32'h0, 10'h0, 11'd0}},
    '{'{OP_REMOVE, 10'h3ff, 32'h0000_0000, 10'h000}, KNOWN,   '{STAT_ABSENT, 32'h0, 10'h0, 11'd0}},
    '{'{OP_INSERT, 10'h000, 32'h0000_0000, 10'h3ff}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd1}},
    '{'{OP_INSERT, 10'h3ff, 32'hffff_ffff, 10'h000}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd2}},
    '{'{OP_INSERT, 10'h155, 32'ha5a5_a5a5, 10'h2aa}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd3}},
    '{'{OP_INSERT, 10'h2aa, 32'h5a5a_5a5a, 10'h155}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd4}},
    '{'{OP_LOOKUP, 10'h3ff, 32'h0000_0000, 10'h000}, KNOWN,
      '{STAT_DONE, 32'hffff_ffff, 10'h0, 11'd4}},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h001}, KNOWN,
      '{STAT_DONE, 32'hffff_ffff, 10'h3ff, 11'd4}},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h004}, KNOWN,   '{STAT_BEYOND, 32'h0, 10'h0, 11'd4}},
    '{'{OP_INSERT, 10'h3ff, 32'h1234_5678, 10'h000}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd4}},
    '{'{OP_LOOKUP, 10'h3ff, 32'hffff_ffff, 10'h3ff}, KNOWN,
      '{STAT_DONE, 32'h1234_5678, 10'h0, 11'd4}},
    '{'{OP_REMOVE, 10'h000, 32'hffff_ffff, 10'h3ff}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd3}},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h000}, KNOWN,
      '{STAT_DONE, 32'h5a5a_5a5a, 10'h2aa, 11'd3}},
    '{'{OP_LOOKUP, 10'h2aa, 32'h0000_0000, 10'h000}, KNOWN,
      '{STAT_DONE, 32'h5a5a_5a5a, 10'h0, 11'd3}},
    '{'{OP_LOOKUP, 10'h000, 32'h0000_0000, 10'h000}, KNOWN,   '{STAT_ABSENT, 32'h0, 10'h0, 11'd3}},
    '{'{OP_REMOVE, 10'h000, 32'h0000_0000, 10'h000}, KNOWN,   '{STAT_ABSENT, 32'h0, 10'h0, 11'd3}},
    '{'{OP_REMOVE, 10'h2aa, 32'h0000_0000, 10'h000}, DERIVED, '0},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h000}, DERIVED, '0},
    '{'{OP_REMOVE, 10'h155, 32'h0000_0000, 10'h000}, DERIVED, '0},
    '{'{OP_REMOVE, 10'h3ff, 32'h0000_0000, 10'h000}, DERIVED, '0},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h3ff}, KNOWN,   '{STAT_BEYOND, 32'h0, 10'h0, 11'd0}},
    '{'{OP_LOOKUP, 10'h3ff, 32'h0000_0000, 10'h000}, KNOWN,   '{STAT_ABSENT, 32'h0, 10'h0, 11'd0}},
    '{'{OP_INSERT, 10'h3ff, 32'h0000_0000, 10'h000}, KNOWN,   '{STAT_DONE,   32'h0, 10'h0, 11'd1}},
    '{'{OP_READ,   10'h000, 32'h0000_0000, 10'h000}, KNOWN,
      '{STAT_DONE, 32'h0, 10'h3ff, 11'd1}}
  };

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_word   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_word;

  sparse_set_component_pool_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  // Shadow copy of the pool
  bit          ent_present [ENTITIES];
  bit [9:0]    ent_slot    [ENTITIES];
  bit [31:0]   slot_value  [POOL_SLOTS];
  bit [9:0]    slot_owner  [POOL_SLOTS];
  int unsigned live_n = 0;

  out_t pending_results [$];
  int   bad_results = 0;
  int   send_idle_pct = 23;
  int   recv_idle_pct = 87;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  out_t want_word;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t pool_apply(input in_t w);
    out_t        r;
    bit          hit;
    int unsigned s;
    int unsigned last;
    bit [9:0]    moved;
    r = '0;
    r.status = STAT_DONE;
    s = ent_slot[w.entity_id];
    hit = ent_present[w.entity_id] && (s < live_n);
    case (w.opcode)
      OP_INSERT: begin
        if (hit) begin
          slot_value[s] = w.component_value;
        end else if (live_n >= POOL_SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          slot_value[live_n] = w.component_value;
          slot_owner[live_n] = w.entity_id;
          ent_slot[w.entity_id] = 10'(live_n);
          ent_present[w.entity_id] = 1'b1;
          live_n++;
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          r.status = STAT_ABSENT;
        end else begin
          // swap-and-pop: last entry fills the hole, its owner is repointed
          last = live_n - 1;
          ent_present[w.entity_id] = 1'b0;
          if (s != last) begin
            moved = slot_owner[last];
            slot_value[s] = slot_value[last];
            slot_owner[s] = moved;
            ent_slot[moved] = 10'(s);
          end
          live_n = last;
        end
      end
      OP_LOOKUP: begin
        if (hit) r.data_out = slot_value[s];
        else r.status = STAT_ABSENT;
      end
      default: begin
        if (w.slot_index < live_n) begin
          r.data_out = slot_value[w.slot_index];
          r.entity_out = slot_owner[w.slot_index];
        end else begin
          r.status = STAT_BEYOND;
        end
      end
    endcase
    r.live_count = 11'(live_n);
    return r;
  endfunction

  function automatic op_e pick_op(input int ins, input int rem, input int look);
    int r;
    r = $urandom_range(99);
    if (r < ins) return OP_INSERT;
    if (r < ins + rem) return OP_REMOVE;
    if (r < ins + rem + look) return OP_LOOKUP;
    return OP_READ;
  endfunction

  // Reads mostly land between slot 0 and one past the live count, now and then anywhere.
  function automatic bit [9:0] pick_slot();
    if ($urandom_range(3) != 0) return 10'($urandom_range(live_n + 1));
    return 10'($urandom);
  endfunction

  // Called at a rising edge. Holds the word until taken, then records what must come back.
  task automatic offer_word(input in_t w, input bit known, input out_t fixed);
    int   gap;
    out_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    r = pool_apply(w);
    pending_results.insert(pending_results.size(), known ? fixed : r);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected word %p", out_word);
      end else begin
        want_word = pending_results.pop_front();
        if (out_word.status !== want_word.status || out_word.data_out !== want_word.data_out
            || out_word.entity_out !== want_word.entity_out
            || out_word.live_count !== want_word.live_count) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: exp st=%0d data=%h ent=%h cnt=%0d  got st=%0d data=%h ent=%h cnt=%0d",
                     want_word.status, want_word.data_out, want_word.entity_out,
                     want_word.live_count, out_word.status, out_word.data_out,
                     out_word.entity_out, out_word.live_count);
        end
      end
    end
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_t      w;
    bit [9:0] e;
    op_e      op;
    int       r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_PROBES; i++) offer_word(PROBES[i].word, PROBES[i].known, PROBES[i].res);

    // Mixed traffic over a small set of entities so that hits and moves are common
    for (int i = 0; i < 50; i++) begin
      op = pick_op(35, 25, 20);
      e = ($urandom_range(9) < 7) ? 10'($urandom_range(31)) : 10'($urandom);
      w = '{op, e, 32'($urandom), (op == OP_READ) ? pick_slot() : 10'($urandom)};
      offer_word(w, DERIVED, '0);
    end

    // Fill to capacity. Every entity is then present, so a further insert only overwrites.
    send_idle_pct = 87;
    recv_idle_pct = 23;
    while (live_n < POOL_SLOTS) begin
      r = $urandom_range(99);
      e = 10'($urandom);
      if (r < 95) begin
        while (ent_present[e]) e = e + 10'd1;
        w = '{OP_INSERT, e, 32'($urandom), 10'($urandom)};
      end else if (r < 97) begin
        w = '{OP_LOOKUP, e, 32'($urandom), 10'($urandom)};
      end else if (r < 99) begin
        w = '{OP_READ, e, 32'($urandom), pick_slot()};
      end else begin
        w = '{OP_INSERT, e, 32'($urandom), 10'($urandom)};
      end
      offer_word(w, DERIVED, '0);
    end
    offer_word('{OP_READ, 10'h000, 32'h0, 10'h3ff}, DERIVED, '0);
    offer_word('{OP_INSERT, 10'h3ff, 32'($urandom), 10'h0}, DERIVED, '0);

    // No idling; the receiver stalls for a long stretch first so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    for (int i = 0; i < 100; i++) begin
      op = pick_op(20, 40, 20);
      w = '{op, 10'($urandom), 32'($urandom), (op == OP_READ) ? pick_slot() : 10'($urandom)};
      offer_word(w, DERIVED, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/sscp_pkg.sv
hdl/sscp_ram.sv
hdl/sparse_set_component_pool_unit.sv
tb/sparse_set_component_pool_unit_test.sv
